/* rtl/ccl_pkg.sv */
package ccl_pkg;

   // Counter and result widths
   localparam int CountWidth  = 32;
   localparam int ExtWidth    = 64;
   localparam int DivWidth    = 10;
   localparam int SecWidth    = 45;
   localparam int DeltaWidth  = 32;

   localparam logic [CountWidth-1:0] CountMask =
      CountWidth'((64'd1 << CountWidth) - 64'd1);

   // Clock rate register
   localparam logic [DivWidth-1:0] ResetMhz    = DivWidth'(240);
   localparam logic [DivWidth-1:0] DigitRadix  = DivWidth'(1000);

   // Step counter of the bit-serial division chain: one dividend bit per
   // cycle through three stages, each stage in the cycle after the one before
   localparam int DivBits   = ExtWidth;
   localparam int StepLast  = DivBits + 2;
   localparam int StepWidth = $clog2(StepLast + 1);

   typedef enum logic [1:0] {
      CCL_IDLE,
      CCL_RUN,
      CCL_HOLD
   } ccl_state_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } ccl_stage_ctrl_type;

endpackage

/* rtl/ccl_if.sv */
interface ccl_req_if import ccl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CountWidth-1:0] count_now;
   logic [CountWidth-1:0] prev_count;

   modport source (output valid, output count_now, output prev_count, input ready);
   modport sink   (input valid, input count_now, input prev_count, output ready);
endinterface

interface ccl_rsp_if import ccl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [DeltaWidth-1:0] delta_cycles;
   logic [ExtWidth-1:0]   extended_count;
   logic [SecWidth-1:0]   seconds;
   logic [DivWidth-1:0]   millis;
   logic [DivWidth-1:0]   micros;
   logic [ExtWidth-1:0]   total_us;

   modport source (output valid, output delta_cycles, output extended_count,
                   output seconds, output millis, output micros, output total_us,
                   input ready);
   modport sink   (input valid, input delta_cycles, input extended_count,
                   input seconds, input millis, input micros, input total_us,
                   output ready);
endinterface

/* rtl/ccl_div_stage.sv */
module ccl_div_stage import ccl_pkg::*; (
   input  logic                clock,
   input  ccl_stage_ctrl_type  ctrl,
   input  logic                bit_in,
   input  logic [DivWidth-1:0] divisor,
   output logic                quo_bit,
   output logic [DivWidth-1:0] remainder
);

   logic [DivWidth-1:0] rem_ff, rem_in;
   logic                quo_ff, quo_in;
   logic [DivWidth:0]   trial;
   logic [DivWidth:0]   diff;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, bit_in};
      diff   = trial - {1'b0, divisor};
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (ctrl.clear) begin
         rem_in = '0;
         quo_in = 1'b0;
      end else if (ctrl.shift) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[DivWidth-1:0];
            quo_in = 1'b1;
         end else begin
            rem_in = trial[DivWidth-1:0];
            quo_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quo_bit   = quo_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/ccl_wrap.sv */
module ccl_wrap import ccl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  update,
   input  logic [CountWidth-1:0] now,
   output logic [ExtWidth-1:0]   ext_count
);

   logic [31:0]           wrap_ff, wrap_in;
   logic [CountWidth-1:0] last_ff, last_in;
   logic [31:0]           wrap_next;

   // Count a wrap when the new sample falls below the last one
   always_comb begin
      wrap_next = (now < last_ff) ? wrap_ff + 32'd1 : wrap_ff;
      ext_count = (ExtWidth'(wrap_next) << CountWidth) + ExtWidth'(now);
      wrap_in   = update ? wrap_next : wrap_ff;
      last_in   = update ? now : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff <= '0;
         last_ff <= '0;
      end else begin
         wrap_ff <= wrap_in;
         last_ff <= last_in;
      end
   end

endmodule

/* rtl/cycle_count_timeline_top.sv */
// Cycle counter timeline.
// req_chan carries one transaction per timestamp: a sample of the free-running
// cycle counter (count_now) and an earlier sample of the caller (prev_count).
// rsp_chan returns one transaction per request: the wrapping cycle difference,
// the counter extended to 64 bits by a wrap count, and that count converted
// to seconds, milliseconds, microseconds and total microseconds.
// csr_wr_en / csr_wr_data write the clock rate in cycles per microsecond;
// a rate of zero divides as one. Write it only while the block is idle.
// The conversion is bit-serial: the extended count enters a restoring divider
// by the clock rate MSB first, one bit per cycle, and its quotient bits feed
// two more one-bit dividers by 1000, each taking its bits in the cycle after
// the divider before it. A new request is taken only after the last result
// has moved to the response register. req_chan.ready is high only while no
// transaction is in work.
// A finished result waits in the response register; while the receiver stalls
// the next request is accepted and processed, then held until the register
// frees. Reset clears the wrap count, the last sample, the control state and
// the response valid, and sets the clock rate to 240.
module cycle_count_timeline_top import ccl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   ccl_req_if.sink             req_chan,
   ccl_rsp_if.source           rsp_chan,
   input  logic                csr_wr_en,
   input  logic [DivWidth-1:0] csr_wr_data
);

   ccl_state_type          state_ff, state_in;
   logic [StepWidth-1:0]   step_ff, step_in;
   logic [DivWidth-1:0]    mhz_ff, mhz_in;
   logic [DivWidth-1:0]    divisor;

   logic                   accept;
   logic                   out_free;
   logic                   load_out;

   logic [CountWidth-1:0]  now_masked;
   logic [CountWidth-1:0]  prev_masked;
   logic [ExtWidth-1:0]    ext_count;

   // Working registers
   logic [ExtWidth-1:0]    dividend_ff, dividend_in;
   logic [DeltaWidth-1:0]  delta_ff, delta_in;
   logic [ExtWidth-1:0]    total_ff, total_in;
   logic [SecWidth-1:0]    sec_ff, sec_in;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DeltaWidth-1:0]  rsp_delta_ff, rsp_delta_in;
   logic [ExtWidth-1:0]    rsp_ext_ff, rsp_ext_in;
   logic [SecWidth-1:0]    rsp_sec_ff, rsp_sec_in;
   logic [DivWidth-1:0]    rsp_ms_ff, rsp_ms_in;
   logic [DivWidth-1:0]    rsp_us_ff, rsp_us_in;
   logic [ExtWidth-1:0]    rsp_total_ff, rsp_total_in;

   ccl_stage_ctrl_type     rate_ctrl, us_ctrl, ms_ctrl;
   logic                   rate_quo, us_quo, ms_quo;
   logic [DivWidth-1:0]    rate_rem, us_rem, ms_rem;
   logic                   sec_shift;
   logic                   running;

   assign now_masked  = req_chan.count_now & CountMask;
   assign prev_masked = req_chan.prev_count & CountMask;
   assign divisor     = (mhz_ff == '0) ? DivWidth'(1) : mhz_ff;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == CCL_IDLE);

   // Control sequence: idle, shift 64 bits through the chain, hand off result
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      load_out = 1'b0;
      case (state_ff)
         CCL_IDLE: begin
            if (accept) begin
               state_in = CCL_RUN;
               step_in  = '0;
            end
         end
         CCL_RUN: begin
            if (step_ff == StepWidth'(StepLast)) begin
               state_in = CCL_HOLD;
            end else begin
               step_in = step_ff + StepWidth'(1);
            end
         end
         CCL_HOLD: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = CCL_IDLE;
            end
         end
         default: begin
            state_in = CCL_IDLE;
         end
      endcase
   end

   // Each stage shifts all 64 dividend bits, in the cycle after the one before it
   assign running         = (state_ff == CCL_RUN);
   assign rate_ctrl.clear = accept;
   assign rate_ctrl.shift = running && (step_ff <= StepWidth'(DivBits - 1));
   assign us_ctrl.clear   = accept;
   assign us_ctrl.shift   = running && (step_ff >= StepWidth'(1))
                            && (step_ff <= StepWidth'(DivBits));
   assign ms_ctrl.clear   = accept;
   assign ms_ctrl.shift   = running && (step_ff >= StepWidth'(2))
                            && (step_ff <= StepWidth'(DivBits + 1));
   assign sec_shift       = running && (step_ff >= StepWidth'(3));

   // Track wraps and extend the counter
   ccl_wrap u_wrap (
      .clock     (clock),
      .reset     (reset),
      .update    (accept),
      .now       (now_masked),
      .ext_count (ext_count)
   );

   // Divide by the clock rate: quotient is total microseconds
   ccl_div_stage u_rate_div (
      .clock     (clock),
      .ctrl      (rate_ctrl),
      .bit_in    (dividend_ff[ExtWidth-1]),
      .divisor   (divisor),
      .quo_bit   (rate_quo),
      .remainder (rate_rem)
   );

   // Divide total microseconds by 1000: remainder is micros
   ccl_div_stage u_us_div (
      .clock     (clock),
      .ctrl      (us_ctrl),
      .bit_in    (rate_quo),
      .divisor   (DigitRadix),
      .quo_bit   (us_quo),
      .remainder (us_rem)
   );

   // Divide total milliseconds by 1000: remainder is millis, quotient seconds
   ccl_div_stage u_ms_div (
      .clock     (clock),
      .ctrl      (ms_ctrl),
      .bit_in    (us_quo),
      .divisor   (DigitRadix),
      .quo_bit   (ms_quo),
      .remainder (ms_rem)
   );

   always_comb begin
      mhz_in = csr_wr_en ? csr_wr_data : mhz_ff;

      // Rotate the dividend so it is whole again after 64 shifts
      dividend_in = dividend_ff;
      delta_in    = delta_ff;
      if (accept) begin
         dividend_in = ext_count;
         delta_in    = DeltaWidth'((now_masked - prev_masked) & CountMask);
      end else if (rate_ctrl.shift) begin
         dividend_in = {dividend_ff[ExtWidth-2:0], dividend_ff[ExtWidth-1]};
      end

      // Collect quotient bits, dropping what falls off the top
      total_in = us_ctrl.shift ? {total_ff[ExtWidth-2:0], rate_quo} : total_ff;
      sec_in   = sec_shift ? {sec_ff[SecWidth-2:0], ms_quo} : sec_ff;

      // Hold the response until taken
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_delta_in = load_out ? delta_ff    : rsp_delta_ff;
      rsp_ext_in   = load_out ? dividend_ff : rsp_ext_ff;
      rsp_sec_in   = load_out ? sec_ff      : rsp_sec_ff;
      rsp_ms_in    = load_out ? ms_rem      : rsp_ms_ff;
      rsp_us_in    = load_out ? us_rem      : rsp_us_ff;
      rsp_total_in = load_out ? total_ff    : rsp_total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CCL_IDLE;
         step_ff      <= '0;
         mhz_ff       <= ResetMhz;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         mhz_ff       <= mhz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff  <= dividend_in;
      delta_ff     <= delta_in;
      total_ff     <= total_in;
      sec_ff       <= sec_in;
      rsp_delta_ff <= rsp_delta_in;
      rsp_ext_ff   <= rsp_ext_in;
      rsp_sec_ff   <= rsp_sec_in;
      rsp_ms_ff    <= rsp_ms_in;
      rsp_us_ff    <= rsp_us_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.delta_cycles   = rsp_delta_ff;
   assign rsp_chan.extended_count = rsp_ext_ff;
   assign rsp_chan.seconds        = rsp_sec_ff;
   assign rsp_chan.millis         = rsp_ms_ff;
   assign rsp_chan.micros         = rsp_us_ff;
   assign rsp_chan.total_us       = rsp_total_ff;

endmodule

/* bench/tb_cycle_count_timeline_top.sv */
`timescale 1ns / 1ps

module tb_cycle_count_timeline_top;
   import ccl_pkg::*;

   // Wait after the last response before touching the rate register or ending:
   // one full conversion plus margin.
   localparam int SettleCycles = 80;
   // Receiver hold-off long enough to fill the response register and stall req
   localparam int LongHold     = 600;
   // Cycles without any transaction before the run is declared hung
   localparam int IdleLimit    = 5000;
   localparam int PhaseItems   = 130;
   localparam int MaxReports   = 10;

   typedef struct packed {
      logic [DeltaWidth-1:0] delta;
      logic [ExtWidth-1:0]   ext;
      logic [SecWidth-1:0]   sec;
      logic [DivWidth-1:0]   ms;
      logic [DivWidth-1:0]   us;
      logic [ExtWidth-1:0]   total;
   } timeline_type;

   typedef struct {
      logic [CountWidth-1:0] now;
      logic [CountWidth-1:0] prev;
   } stamp_type;

   // Receiver stall styles, one picked per segment
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_LIGHT,
      RX_HEAVY,
      RX_EVERY_THIRD
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid_q = 1'b0;
   logic [CountWidth-1:0] req_now_q   = '0;
   logic [CountWidth-1:0] req_prev_q  = '0;
   logic                  rsp_ready_q = 1'b0;
   logic                  csr_wr_en   = 1'b0;
   logic [DivWidth-1:0]   csr_wr_data = '0;

   ccl_req_if req_chan ();
   ccl_rsp_if rsp_chan ();

   assign req_chan.valid      = req_valid_q;
   assign req_chan.count_now  = req_now_q;
   assign req_chan.prev_count = req_prev_q;
   assign rsp_chan.ready      = rsp_ready_q;

   cycle_count_timeline_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the block's state and rate register
   logic [CountWidth-1:0] wraps_seen = '0;
   logic [CountWidth-1:0] last_count = '0;
   logic [DivWidth-1:0]   rate_mhz   = ResetMhz;

   stamp_type    pending_stamps[$];   // waiting to be offered on req_chan
   timeline_type awaited_times[$];    // predicted responses, oldest first

   logic [CountWidth-1:0] stream_pos = '0;  // where the simulated counter stands

   int  fail_count     = 0;
   int  stamps_taken   = 0;
   int  results_seen   = 0;
   int  wrap_events    = 0;
   int  rate_writes    = 0;
   int  hold_asked     = 0;
   int  idle_cycles    = 0;
   logic req_hit = 1'b0;
   logic rsp_hit = 1'b0;

   // Convert one counter sample to the timeline; advances the wrap state.
   function automatic timeline_type stamp_timeline(input logic [CountWidth-1:0] now,
                                                   input logic [CountWidth-1:0] prev);
      timeline_type r;
      logic [63:0]  mhz, hz, hz_ms, ext, sec, rest, ms, us;
      mhz   = (rate_mhz == '0) ? 64'd1 : 64'(rate_mhz);
      hz    = mhz * 64'd1000000;
      hz_ms = mhz * 64'd1000;
      if (now < last_count) begin
         wraps_seen  = wraps_seen + 1'b1;
         wrap_events = wrap_events + 1;
      end
      last_count = now;
      ext  = {wraps_seen, now};
      sec  = ext / hz;
      rest = ext - sec * hz;
      ms   = rest / hz_ms;
      us   = (rest - ms * hz_ms) / mhz;
      r.delta = now - prev;
      r.ext   = ext;
      r.sec   = sec[SecWidth-1:0];
      r.ms    = ms[DivWidth-1:0];
      r.us    = us[DivWidth-1:0];
      r.total = sec * 64'd1000000 + ms * 64'd1000 + us;
      return r;
   endfunction

   task automatic push_stamp(input logic [CountWidth-1:0] now,
                             input logic [CountWidth-1:0] prev);
      stamp_type s;
      s.now  = now;
      s.prev = prev;
      pending_stamps.push_back(s);
      stream_pos = now;
   endtask

   // Mostly a counter that moves forward by steps of every magnitude (wrapping
   // now and then), with repeats and fully random samples mixed in.
   task automatic queue_random(input int count);
      logic [CountWidth:0]   step;
      logic [CountWidth-1:0] now, prev, earlier;
      int                    pick;
      for (int i = 0; i < count; i++) begin
         pick    = $urandom_range(0, 9);
         earlier = stream_pos;
         if (pick <= 6) begin
            step = {1'b0, $urandom} >> $urandom_range(0, 32);
            now  = stream_pos + step[CountWidth-1:0];
            if ($urandom_range(0, 1) == 1)
               prev = now - ($urandom >> $urandom_range(0, 31));
            else
               prev = earlier;
         end else if (pick <= 8) begin
            now  = $urandom;
            prev = $urandom;
         end else begin
            // same sample again: no wrap
            now  = stream_pos;
            prev = $urandom;
         end
         push_stamp(now, prev);
      end
   endtask

   task automatic wait_all_answered();
      while (pending_stamps.size() != 0 || awaited_times.size() != 0)
         @(posedge clock);
   endtask

   // Drain, let the divider settle, then write the clock rate.
   task automatic set_rate(input logic [DivWidth-1:0] mhz);
      wait_all_answered();
      repeat (SettleCycles) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mhz;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      rate_mhz    = mhz;
      rate_writes = rate_writes + 1;
   endtask

   // Record accepted requests and predict their responses.
   always @(posedge clock) begin : req_watch
      if (!reset && req_chan.valid && req_chan.ready) begin
         awaited_times.push_back(stamp_timeline(req_chan.count_now, req_chan.prev_count));
         stamps_taken = stamps_taken + 1;
         req_hit <= 1'b1;
      end else begin
         req_hit <= 1'b0;
      end
   end

   // Sender: bursts of random length, random gaps after a burst ends.
   // Valid only drops after an accept, so an offered transaction is never withdrawn.
   int burst_left = 1;
   int gap_left   = 0;

   always @(negedge clock) begin : req_drive
      logic       valid_next;
      stamp_type  head;
      valid_next = 1'b0;
      if (!reset) begin
         if (req_hit) begin
            void'(pending_stamps.pop_front());
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               // occasionally a long burst with no gaps at all
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                        : $urandom_range(1, 8);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
            end
         end
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
         end else if (pending_stamps.size() != 0) begin
            head       = pending_stamps[0];
            valid_next = 1'b1;
            req_now_q  <= head.now;
            req_prev_q <= head.prev;
         end
      end
      req_valid_q <= valid_next;
   end

   // Receiver: segments of random stall styles, plus long hold-offs on request.
   int          hold_left   = 0;
   int          hold_served = 0;
   int          seg_left    = 0;
   int          rx_tick     = 0;
   rx_mode_type rx_mode     = RX_OPEN;

   always @(negedge clock) begin : rsp_stall
      logic ready_next;
      ready_next = 1'b0;
      rx_tick    = rx_tick + 1;
      if (reset) begin
         ready_next = 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
      end else if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left   = LongHold;
      end else begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(20, 200);
            rx_mode  = rx_mode_type'($urandom_range(0, 3));
         end
         seg_left = seg_left - 1;
         case (rx_mode)
            RX_OPEN:        ready_next = 1'b1;
            RX_LIGHT:       ready_next = ($urandom_range(0, 3) != 0);
            RX_HEAVY:       ready_next = ($urandom_range(0, 3) == 0);
            RX_EVERY_THIRD: ready_next = (rx_tick % 3 == 0);
            default:        ready_next = 1'b1;
         endcase
      end
      rsp_ready_q <= ready_next;
   end

   // Check each accepted response against the oldest prediction.
   always @(posedge clock) begin : rsp_watch
      timeline_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_hit <= 1'b1;
         got = '{delta: rsp_chan.delta_cycles, ext: rsp_chan.extended_count,
                 sec: rsp_chan.seconds, ms: rsp_chan.millis,
                 us: rsp_chan.micros, total: rsp_chan.total_us};
         if (awaited_times.size() == 0) begin
            fail_count = fail_count + 1;
            if (fail_count <= MaxReports)
               $display("%0t: response with nothing outstanding", $realtime);
         end else begin
            want = awaited_times.pop_front();
            results_seen = results_seen + 1;
            if (got !== want) begin
               fail_count = fail_count + 1;
               if (fail_count <= MaxReports) begin
                  $display("%0t: response %0d mismatch", $realtime, results_seen);
                  $display("  expected delta=%h ext=%h sec=%0d ms=%0d us=%0d total=%0d",
                           want.delta, want.ext, want.sec, want.ms, want.us, want.total);
                  $display("  actual   delta=%h ext=%h sec=%0d ms=%0d us=%0d total=%0d",
                           got.delta, got.ext, got.sec, got.ms, got.us, got.total);
               end
            end
         end
      end else begin
         rsp_hit <= 1'b0;
      end
   end

   // Watchdog: end the run if no transaction moves for too long.
   always @(posedge clock) begin : hang_watch
      if (req_hit || rsp_hit)
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("%0t: no transaction for %0d cycles", $realtime, IdleLimit);
         $display("Verification failed");
         $finish;
      end
   end

   // Stimulus. The wrap counter rolling over needs 2^32 wraps and is out of
   // reach; the counter is full width, so no sample bits are masked off.
   initial begin : run
      logic [DivWidth-1:0] rate_plan [7];
      rate_plan = '{DivWidth'(1000), DivWidth'($urandom_range(1, 1000)), DivWidth'(1023),
                    DivWidth'(0), DivWidth'($urandom_range(1, 1000)), DivWidth'(1),
                    ResetMhz};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset rate: counter extremes, equal samples, wraps, unit boundaries
      push_stamp(32'h0000_0000, 32'h0000_0000);   // equal to the reset sample
      push_stamp(32'hFFFF_FFFF, 32'h0000_0000);
      push_stamp(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // equal again, no wrap
      push_stamp(32'h0000_0000, 32'hFFFF_FFFF);   // wrap, delta of one
      push_stamp(32'd5, 32'd10);                  // delta wraps backward
      push_stamp(32'd239, 32'd0);
      push_stamp(32'd240, 32'd239);
      push_stamp(32'd239_999, 32'd0);
      push_stamp(32'd240_000, 32'd0);
      push_stamp(32'd239_999_999, 32'd0);
      push_stamp(32'd240_000_000, 32'd0);
      push_stamp(32'hAAAA_AAAA, 32'h5555_5555);
      push_stamp(32'h5555_5555, 32'hAAAA_AAAA);   // wrap

      // Slowest rate: large second counts
      set_rate(DivWidth'(1));
      push_stamp(32'd999, 32'd0);
      push_stamp(32'd1000, 32'd999);
      push_stamp(32'd999_999, 32'd0);
      push_stamp(32'd1_000_000, 32'd0);
      push_stamp(32'hFFFF_FFFF, 32'd0);
      push_stamp(32'h0000_0000, 32'hFFFF_FFFF);

      // Zero rate divides as one
      set_rate(DivWidth'(0));
      push_stamp(32'd1000, 32'd0);
      push_stamp(32'd0, 32'd1000);

      // Rate above the nominal range, all register bits set
      set_rate(DivWidth'(1023));
      push_stamp(32'hFFFF_FFFF, 32'd0);
      push_stamp(32'd1022, 32'd0);

      // Random phases, one per rate; the second one starts with a long
      // receiver hold-off while the sender keeps offering
      for (int p = 0; p < 7; p++) begin
         set_rate(rate_plan[p]);
         if (p == 1)
            hold_asked = hold_asked + 1;
         queue_random(PhaseItems);
      end

      wait_all_answered();
      repeat (SettleCycles) @(posedge clock);

      $display("Run covered %0d timestamps and %0d responses over %0d rate writes,",
               stamps_taken, results_seen, rate_writes);
      $display("with %0d counter wraps and %0d failures", wrap_events, fail_count);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* cycle_count_timeline_top.f */
rtl/ccl_pkg.sv
rtl/ccl_if.sv
rtl/ccl_div_stage.sv
rtl/ccl_wrap.sv
rtl/cycle_count_timeline_top.sv
bench/tb_cycle_count_timeline_top.sv
